// File: hdl/sads_pkg.sv
// shared types and constants of the sensor adc sequencer
`default_nettype none

package sads_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_CONV_END = 2'd1,
    OP_EXCITE   = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  // converter channel selection
  typedef enum logic [1:0] {
    CH_TEMP = 2'd0,
    CH_HUM  = 2'd1,
    CH_IR   = 2'd2,
    CH_NONE = 2'd3
  } channel_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_IDLE_INTERVAL = 3'd0,
    REG_WORK_INTERVAL = 3'd1,
    REG_PIR_INTERVAL  = 3'd2,
    REG_PIR_THRESHOLD = 3'd3,
    REG_PIR_DWELL     = 3'd4,
    REG_PIR_ENABLE    = 3'd5,
    REG_PIR_AUTO      = 3'd6,
    REG_SPARE         = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_BITS       = 16;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned THRESH_BITS    = 10;

  // reset values of the configuration registers and of the temperature value
  localparam int unsigned IDLE_INTERVAL_RESET = 50;
  localparam int unsigned WORK_INTERVAL_RESET = 2000;
  localparam int unsigned PIR_INTERVAL_RESET  = 100;
  localparam int unsigned PIR_THRESHOLD_RESET = 12 * 1024 / 33;
  localparam int unsigned PIR_DWELL_RESET     = 0;
  localparam int unsigned TEMP_VALUE_RESET    = 560;

  // presence detection controls
  typedef struct packed {
    logic [THRESH_BITS-1:0] threshold;
    logic                   enable;
    logic                   auto_sample;
  } pir_cfg_t;

  // control fields of one result item
  typedef struct packed {
    channel_t adc_channel;
    logic     adc_start;
    logic     adc_stop;
    logic     excite_timer_start;
    logic     excite_level;
    logic     presence_pulse;
  } ctl_out_t;

endpackage

`default_nettype wire

// File: hdl/sads_alu.sv
// shared add and subtract unit with carry out
`default_nettype none

module sads_alu #(
  parameter int unsigned W = 16
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W-1:0] y,
  output logic              carry
);

  logic [W:0] sum;
  logic [W-1:0] b_op;

  // subtract as add of the inverted operand; carry set means no borrow
  assign b_op = sub ? ~b : b;
  assign sum  = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};
  assign y     = sum[W-1:0];
  assign carry = sum[W];

endmodule

`default_nettype wire

// File: hdl/sads_core.sv
// sequencer, running mean and presence logic around one shared adder
`default_nettype none

module sads_core #(
  parameter int unsigned WINDOW_DEPTH = 5,
  parameter int unsigned SAMPLE_BITS  = 10,
  parameter int unsigned TICK_BITS    = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic [1:0]              in_op,
  input  wire logic [TICK_BITS-1:0]    in_now,
  input  wire logic [SAMPLE_BITS-1:0]  in_adc,
  input  wire logic                    in_work,
  output logic                         ready,
  input  wire logic [TICK_BITS-1:0]    idle_interval,
  input  wire logic [TICK_BITS-1:0]    work_interval,
  input  wire logic [TICK_BITS-1:0]    pir_interval,
  input  wire logic [TICK_BITS-1:0]    pir_dwell,
  input  wire sads_pkg::pir_cfg_t      pir_cfg,
  input  wire logic                    out_free,
  output logic                         res_valid,
  output sads_pkg::ctl_out_t           res_ctl,
  output logic [SAMPLE_BITS-1:0]       res_temp,
  output logic [SAMPLE_BITS-1:0]       res_hum,
  output logic [SAMPLE_BITS-1:0]       res_ir
);

  import sads_pkg::*;

  localparam int unsigned POS_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W   = SAMPLE_BITS + FILL_W;
  localparam int unsigned REM_W   = FILL_W + 1;
  localparam int unsigned ALU_W   = (TICK_BITS > SUM_W) ? TICK_BITS : SUM_W;
  localparam int unsigned CNT_W   = $clog2(SUM_W + 1);
  localparam int unsigned CMP_W   = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECODE = 8'b0000_0010,
    ST_DIFF   = 8'b0000_0100,
    ST_CMP    = 8'b0000_1000,
    ST_WRITE  = 8'b0001_0000,
    ST_SUM    = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_TEMP = 4'b0010,
    SEQ_HUM  = 4'b0100,
    SEQ_IR   = 4'b1000
  } seq_t;

  typedef enum logic [4:0] {
    HP_INIT    = 5'b00001,
    HP_IDLE    = 5'b00010,
    HP_START   = 5'b00100,
    HP_WORKING = 5'b01000,
    HP_END     = 5'b10000
  } hum_phase_t;

  typedef enum logic [3:0] {
    PR_IDLE      = 4'b0001,
    PR_PRESENT   = 4'b0010,
    PR_SIGNALLED = 4'b0100,
    PR_DISABLED  = 4'b1000
  } presence_t;

  // which elapsed-tick test the adder is working on
  typedef enum logic [1:0] {
    TEST_TEMP  = 2'd0,
    TEST_HUM   = 2'd1,
    TEST_IR    = 2'd2,
    TEST_DWELL = 2'd3
  } test_t;

  state_t     state;
  seq_t       seq;
  hum_phase_t hum_phase;
  presence_t  presence;
  test_t      test;

  // latched input item
  op_t                  op;
  logic [TICK_BITS-1:0] now;
  logic [SAMPLE_BITS-1:0] adc;
  logic                 work;

  logic                   busy;
  logic [TICK_BITS-1:0]   temp_last;
  logic [TICK_BITS-1:0]   hum_last;
  logic [TICK_BITS-1:0]   ir_last;
  logic [TICK_BITS-1:0]   pres_start;
  logic [POS_W-1:0]       pos;
  logic [FILL_W-1:0]      fill;
  logic [SAMPLE_BITS-1:0] temp_val;
  logic [SAMPLE_BITS-1:0] hum_val;
  logic [SAMPLE_BITS-1:0] ir_val;
  logic                   excite_phase;
  channel_t               channel;
  logic                   level;
  logic                   p_start;
  logic                   p_stop;
  logic                   p_tstart;
  logic                   p_pulse;

  // working registers of the shared adder
  logic [TICK_BITS-1:0]   diff;
  logic [SUM_W-1:0]       acc;
  logic [REM_W-1:0]       rem;
  logic [FILL_W-1:0]      rd_idx;
  logic                   rd_vld;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [CNT_W-1:0]       div_cnt;

  logic [SAMPLE_BITS-1:0] win [WINDOW_DEPTH];
  logic                   win_we;
  logic                   rd_issue;

  logic [ALU_W-1:0]     alu_a;
  logic [ALU_W-1:0]     alu_b;
  logic                 alu_sub;
  logic [ALU_W-1:0]     alu_y;
  logic                 alu_carry;
  logic [TICK_BITS-1:0] last_sel;
  logic [TICK_BITS-1:0] iv_sel;
  logic [REM_W-1:0]     rem_shift;
  logic                 below_thr;
  logic                 above_thr;

  sads_alu #(.W(ALU_W)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .y     (alu_y),
    .carry (alu_carry)
  );

  // operand selection for the elapsed test
  always_comb begin
    case (test)
      TEST_TEMP:  last_sel = temp_last;
      TEST_HUM:   last_sel = hum_last;
      TEST_IR:    last_sel = ir_last;
      TEST_DWELL: last_sel = pres_start;
      default:    last_sel = pres_start;
    endcase
    case (test)
      TEST_TEMP,
      TEST_HUM:   iv_sel = work ? work_interval : idle_interval;
      TEST_IR:    iv_sel = pir_interval;
      TEST_DWELL: iv_sel = pir_dwell;
      default:    iv_sel = pir_dwell;
    endcase
  end

  assign rem_shift = {rem[REM_W-2:0], acc[SUM_W-1]};

  // adder operands per step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state)
      ST_DIFF: begin
        alu_a = ALU_W'(now);
        alu_b = ALU_W'(last_sel);
      end
      ST_CMP: begin
        alu_a = ALU_W'(diff);
        alu_b = ALU_W'(iv_sel);
      end
      ST_SUM: begin
        alu_a   = ALU_W'(acc);
        alu_b   = ALU_W'(rd_data);
        alu_sub = 1'b0;
      end
      ST_DIV: begin
        alu_a = ALU_W'(rem_shift);
        alu_b = ALU_W'(fill);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign below_thr = CMP_W'(adc) < CMP_W'(pir_cfg.threshold);
  assign above_thr = CMP_W'(adc) > CMP_W'(pir_cfg.threshold);
  assign win_we    = (state == ST_WRITE);
  assign rd_issue  = (state == ST_SUM) && (rd_idx < fill);

  // averaging window store
  always_ff @(posedge clk) begin
    if (win_we) begin
      win[pos] <= adc;
    end
    if (rd_issue) begin
      rd_data <= win[rd_idx[POS_W-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seq          <= SEQ_IDLE;
      hum_phase    <= HP_INIT;
      presence     <= PR_IDLE;
      test         <= TEST_TEMP;
      busy         <= 1'b0;
      temp_last    <= '0;
      hum_last     <= '0;
      ir_last      <= '0;
      pres_start   <= '0;
      pos          <= '0;
      fill         <= '0;
      temp_val     <= SAMPLE_BITS'(TEMP_VALUE_RESET);
      hum_val      <= '0;
      ir_val       <= '0;
      excite_phase <= 1'b0;
      channel      <= CH_TEMP;
      level        <= 1'b0;
      p_start      <= 1'b0;
      p_stop       <= 1'b0;
      p_tstart     <= 1'b0;
      p_pulse      <= 1'b0;
      rd_idx       <= '0;
      rd_vld       <= 1'b0;
      div_cnt      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op       <= op_t'(in_op);
            now      <= in_now;
            adc      <= in_adc;
            work     <= in_work;
            p_start  <= 1'b0;
            p_stop   <= 1'b0;
            p_tstart <= 1'b0;
            p_pulse  <= 1'b0;
            state    <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          state <= ST_DONE;
          case (op)
            OP_CONV_END: begin
              busy <= 1'b0;
            end
            OP_EXCITE: begin
              if (excite_phase) begin
                level <= 1'b1;
                if (hum_phase == HP_START) begin
                  p_start   <= 1'b1;
                  hum_phase <= HP_WORKING;
                end
              end else begin
                if (hum_phase == HP_WORKING) begin
                  hum_val   <= adc;
                  p_stop    <= 1'b1;
                  hum_phase <= HP_END;
                end
                level <= 1'b0;
              end
              excite_phase <= ~excite_phase;
            end
            OP_POLL: begin
              case (seq)
                SEQ_IDLE: begin
                  test  <= TEST_TEMP;
                  state <= ST_DIFF;
                end
                SEQ_TEMP: begin
                  if (!busy) begin
                    p_stop <= 1'b1;
                    seq    <= SEQ_IDLE;
                    state  <= ST_WRITE;
                  end
                end
                SEQ_HUM: begin
                  if (hum_phase == HP_END) begin
                    p_stop    <= 1'b1;
                    hum_phase <= HP_IDLE;
                    seq       <= SEQ_IDLE;
                  end
                end
                default: begin
                  if (!busy) begin
                    p_stop <= 1'b1;
                    ir_val <= adc;
                    seq    <= SEQ_IDLE;
                    // presence machine sees the fresh infrared sample
                    case (presence)
                      PR_PRESENT: begin
                        if (below_thr) begin
                          presence <= PR_IDLE;
                        end else begin
                          test  <= TEST_DWELL;
                          state <= ST_DIFF;
                        end
                      end
                      PR_SIGNALLED: begin
                        if (below_thr) begin
                          presence <= PR_IDLE;
                        end
                      end
                      PR_DISABLED: begin
                        if (pir_cfg.enable) begin
                          presence <= PR_IDLE;
                        end
                      end
                      default: begin
                        if (!pir_cfg.enable) begin
                          presence <= PR_DISABLED;
                        end else if (above_thr) begin
                          presence <= PR_PRESENT;
                        end
                        if (above_thr) begin
                          pres_start <= now;
                        end
                      end
                    endcase
                  end
                end
              endcase
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end

        // ticks since the last start, modulo the tick width
        ST_DIFF: begin
          diff  <= alu_y[TICK_BITS-1:0];
          state <= ST_CMP;
        end

        // elapsed test: no borrow means the interval is reached
        ST_CMP: begin
          state <= ST_DONE;
          case (test)
            TEST_TEMP: begin
              if (alu_carry) begin
                p_stop    <= 1'b1;
                p_start   <= 1'b1;
                channel   <= CH_TEMP;
                busy      <= 1'b1;
                seq       <= SEQ_TEMP;
                temp_last <= now;
              end else begin
                test  <= TEST_HUM;
                state <= ST_DIFF;
              end
            end
            TEST_HUM: begin
              if (alu_carry) begin
                p_stop    <= 1'b1;
                channel   <= CH_HUM;
                p_tstart  <= (hum_phase == HP_INIT);
                hum_phase <= HP_START;
                seq       <= SEQ_HUM;
                hum_last  <= now;
              end else if (pir_cfg.auto_sample) begin
                test  <= TEST_IR;
                state <= ST_DIFF;
              end
            end
            TEST_IR: begin
              if (alu_carry) begin
                p_stop  <= 1'b1;
                p_start <= 1'b1;
                channel <= CH_IR;
                busy    <= 1'b1;
                seq     <= SEQ_IR;
                ir_last <= now;
              end
            end
            default: begin
              if (alu_carry) begin
                p_pulse  <= 1'b1;
                presence <= PR_SIGNALLED;
              end
            end
          endcase
        end

        // store the sample and advance the window
        ST_WRITE: begin
          pos    <= (pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos + 1'b1;
          fill   <= (fill < FILL_W'(WINDOW_DEPTH)) ? fill + 1'b1 : fill;
          rd_idx <= '0;
          rd_vld <= 1'b0;
          acc    <= '0;
          state  <= ST_SUM;
        end

        // one window entry read and added per cycle
        ST_SUM: begin
          rd_vld <= rd_issue;
          if (rd_issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (rd_vld) begin
            acc <= alu_y[SUM_W-1:0];
          end
          if (!rd_issue && !rd_vld) begin
            rem     <= '0;
            div_cnt <= CNT_W'(SUM_W);
            state   <= ST_DIV;
          end
        end

        // restoring division of the sum by the fill, one quotient bit a cycle
        ST_DIV: begin
          if (div_cnt == '0) begin
            temp_val <= acc[SAMPLE_BITS-1:0];
            state    <= ST_DONE;
          end else begin
            rem     <= alu_carry ? alu_y[REM_W-1:0] : rem_shift;
            acc     <= {acc[SUM_W-2:0], alu_carry};
            div_cnt <= div_cnt - 1'b1;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready     = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE) && out_free;

  assign res_ctl.adc_channel        = channel;
  assign res_ctl.adc_start          = p_start;
  assign res_ctl.adc_stop           = p_stop;
  assign res_ctl.excite_timer_start = p_tstart;
  assign res_ctl.excite_level       = level;
  assign res_ctl.presence_pulse     = p_pulse;
  assign res_temp = temp_val;
  assign res_hum  = hum_val;
  assign res_ir   = ir_val;

  // window fill never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");

  // the divider only runs on a window holding at least one sample
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (fill != '0))
    else $error("division with empty window");

  // a busy converter always belongs to a temperature or infrared run
  a_busy_owner: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((seq == SEQ_TEMP) || (seq == SEQ_IR)))
    else $error("converter busy outside a conversion");

endmodule

`default_nettype wire

// File: hdl/sensor_adc_sequencer.sv
// top level of the sensor adc sequencer: channels, configuration and result register
//
// One converter shared by temperature, humidity and infrared channels.
// Input items arrive on s_tvalid/s_tready: the operation (poll step,
// conversion complete, excitation tick) in s_tuser, the tick count, the
// converter reading and the work-mode flag in s_tdata. Each accepted item
// gives exactly one result item on m_tvalid/m_tready with the converter
// controls, the current sample values and the presence pulse.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must see that it is written only while no item is in flight, as the block
// itself does not enforce this. A conversion-complete or excitation item
// passes the states DECODE and DONE before m_tvalid; a poll step also runs
// the states DIFF and CMP for each of up to three elapsed-tick tests, which
// share one adder; a poll that closes a temperature run instead runs WRITE,
// the window sum and the bit-serial divide on the same adder.
// One item is in work at a time: s_tready returns in the same cycle as
// m_tvalid rises for its result.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls further, the block holds the second
// result until the register frees. Reset clears the control and configuration registers.
`default_nettype none

module sensor_adc_sequencer #(
  parameter int unsigned WINDOW_DEPTH = 5,
  parameter int unsigned SAMPLE_BITS  = 10,
  parameter int unsigned TICK_BITS    = 16,
  localparam int unsigned IN_BITS  = TICK_BITS + SAMPLE_BITS + 1,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = 7 + 3 * SAMPLE_BITS,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8,
  localparam int unsigned CFG_W    = (TICK_BITS > sads_pkg::THRESH_BITS) ?
                                     TICK_BITS : sads_pkg::THRESH_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // operation
  input  wire logic [1:0]                           s_tuser,
  // now_tick, adc_value, work_mode
  input  wire logic [IN_W-1:0]                      s_tdata,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // adc_channel, adc_start, adc_stop, excite_timer_start, excite_level,
  // temperature, humidity, infrared, presence_pulse
  output logic [OUT_W-1:0]                          m_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  input  wire logic                                 cfg_we,
  input  wire logic [sads_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]                     cfg_data
);

  import sads_pkg::*;

  logic [TICK_BITS-1:0] idle_interval;
  logic [TICK_BITS-1:0] work_interval;
  logic [TICK_BITS-1:0] pir_interval;
  logic [TICK_BITS-1:0] pir_dwell;
  pir_cfg_t             pir_cfg;

  logic                   out_free;
  logic                   res_valid;
  ctl_out_t               res_ctl;
  logic [SAMPLE_BITS-1:0] res_temp;
  logic [SAMPLE_BITS-1:0] res_hum;
  logic [SAMPLE_BITS-1:0] res_ir;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_interval       <= TICK_BITS'(IDLE_INTERVAL_RESET);
      work_interval       <= TICK_BITS'(WORK_INTERVAL_RESET);
      pir_interval        <= TICK_BITS'(PIR_INTERVAL_RESET);
      pir_dwell           <= TICK_BITS'(PIR_DWELL_RESET);
      pir_cfg.threshold   <= THRESH_BITS'(PIR_THRESHOLD_RESET);
      pir_cfg.enable      <= 1'b1;
      pir_cfg.auto_sample <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IDLE_INTERVAL: idle_interval       <= TICK_BITS'(cfg_data);
        REG_WORK_INTERVAL: work_interval       <= TICK_BITS'(cfg_data);
        REG_PIR_INTERVAL:  pir_interval        <= TICK_BITS'(cfg_data);
        REG_PIR_THRESHOLD: pir_cfg.threshold   <= cfg_data[THRESH_BITS-1:0];
        REG_PIR_DWELL:     pir_dwell           <= TICK_BITS'(cfg_data);
        REG_PIR_ENABLE:    pir_cfg.enable      <= cfg_data[0];
        REG_PIR_AUTO:      pir_cfg.auto_sample <= cfg_data[0];
        default: begin
          pir_cfg <= pir_cfg;
        end
      endcase
    end
  end

  sads_core #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TICK_BITS    (TICK_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_op         (s_tuser),
    .in_now        (s_tdata[TICK_BITS-1:0]),
    .in_adc        (s_tdata[TICK_BITS +: SAMPLE_BITS]),
    .in_work       (s_tdata[TICK_BITS + SAMPLE_BITS]),
    .ready         (s_tready),
    .idle_interval (idle_interval),
    .work_interval (work_interval),
    .pir_interval  (pir_interval),
    .pir_dwell     (pir_dwell),
    .pir_cfg       (pir_cfg),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res_ctl       (res_ctl),
    .res_temp      (res_temp),
    .res_hum       (res_hum),
    .res_ir        (res_ir)
  );

  assign out_free = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= OUT_W'({res_ctl.presence_pulse, res_ir, res_hum, res_temp,
                         res_ctl.excite_level, res_ctl.excite_timer_start,
                         res_ctl.adc_stop, res_ctl.adc_start, res_ctl.adc_channel});
    end
  end

  // a result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // an accepted item keeps the input closed in the following cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in work");

endmodule

`default_nettype wire

// File: tb/sv/sensor_adc_sequencer_checker.sv
// checker for the sensor adc sequencer: watches both item channels and the register port
module sensor_adc_sequencer_checker
  import sads_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                s_tuser,
  input  logic [31:0]               s_tdata,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [39:0]               m_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  output logic [31:0]               mismatches,
  output logic [31:0]               outstanding,
  output logic [31:0]               active_items,
  output logic [31:0]               results_seen,
  output logic [31:0]               presence_pulses,
  output logic [31:0]               averages_done
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AVG_DEPTH = 5;

  typedef enum logic [1:0] {SQ_IDLE, SQ_TEMP, SQ_HUM, SQ_IR} seq_t;
  typedef enum logic [2:0] {HP_INIT, HP_IDLE, HP_START, HP_WORKING, HP_END} hum_phase_t;
  typedef enum logic [1:0] {PS_IDLE, PS_PRESENT, PS_SIGNALLED, PS_DISABLED} presence_t;

  // result fields from the top bit down, so the struct lines up with m_tdata[36:0]
  typedef struct packed {
    logic       presence_pulse;
    logic [9:0] infrared;
    logic [9:0] humidity;
    logic [9:0] temperature;
    logic       excite_level;
    logic       excite_start;
    logic       adc_stop;
    logic       adc_start;
    channel_t   channel;
  } seq_out_t;

  // register copies
  logic [15:0] idle_iv, work_iv, pir_iv, dwell;
  logic [9:0]  threshold;
  logic        enable, auto_ir;

  // sequencer copy
  seq_t        seq;
  logic        busy;
  logic [15:0] temp_last, hum_last, ir_last, pres_start;
  logic [9:0]  window [AVG_DEPTH];
  int          wpos, wfill;
  logic [9:0]  temp_val, hum_val, ir_val;
  presence_t   pres;
  logic        excite_odd;
  hum_phase_t  hphase;
  channel_t    channel;
  logic        level;

  int          bad, seen_n, active_n, pulses_n, averages_n;
  seq_out_t    sequencer_outputs_q [$];

  function automatic logic due(logic [15:0] now, logic [15:0] last, logic [15:0] iv);
    logic [15:0] d;
    d = now - last;
    return d >= iv;
  endfunction

  // running mean over the written part of the window
  function automatic logic [9:0] push_average(logic [9:0] sample);
    int unsigned sum;
    sum = 0;
    window[wpos] = sample;
    wpos = (wpos + 1) % AVG_DEPTH;
    if (wfill < AVG_DEPTH) wfill++;
    for (int i = 0; i < wfill; i++) sum += window[i];
    return 10'(sum / wfill);
  endfunction

  // presence machine, run on each finished infrared sample
  function automatic logic presence_step(logic [15:0] now);
    logic pulse;
    pulse = 1'b0;
    case (pres)
      PS_PRESENT: begin
        if (ir_val < threshold) pres = PS_IDLE;
        else if (due(now, pres_start, dwell)) begin
          pulse = 1'b1;
          pres  = PS_SIGNALLED;
        end
      end
      PS_SIGNALLED: begin
        if (ir_val < threshold) pres = PS_IDLE;
      end
      PS_DISABLED: begin
        if (enable) pres = PS_IDLE;
      end
      default: begin
        if (ir_val > threshold) begin
          pres       = PS_PRESENT;
          pres_start = now;
        end
        // disable wins over a detection on the same sample
        if (!enable) pres = PS_DISABLED;
      end
    endcase
    return pulse;
  endfunction

  task automatic reset_model();
    idle_iv    = 16'(IDLE_INTERVAL_RESET);
    work_iv    = 16'(WORK_INTERVAL_RESET);
    pir_iv     = 16'(PIR_INTERVAL_RESET);
    threshold  = 10'(PIR_THRESHOLD_RESET);
    dwell      = 16'(PIR_DWELL_RESET);
    enable     = 1'b1;
    auto_ir    = 1'b1;
    seq        = SQ_IDLE;
    busy       = 1'b0;
    temp_last  = '0;
    hum_last   = '0;
    ir_last    = '0;
    pres_start = '0;
    wpos       = 0;
    wfill      = 0;
    temp_val   = 10'(TEMP_VALUE_RESET);
    hum_val    = '0;
    ir_val     = '0;
    pres       = PS_IDLE;
    excite_odd = 1'b0;
    hphase     = HP_INIT;
    channel    = CH_TEMP;
    level      = 1'b0;
  endtask

  // works out the result item that one input item causes
  task automatic sequence_step(input op_t op, input logic [15:0] now, input logic [9:0] adc,
                               input logic wm, output seq_out_t r, output logic act);
    logic        start, stop, tstart, pulse, was_busy;
    logic [15:0] iv;
    start    = 1'b0;
    stop     = 1'b0;
    tstart   = 1'b0;
    pulse    = 1'b0;
    was_busy = busy;
    case (op)
      OP_CONV_END: busy = 1'b0;
      OP_EXCITE: begin
        if (excite_odd) begin
          level = 1'b1;
          if (hphase == HP_START) begin
            start  = 1'b1;
            hphase = HP_WORKING;
          end
        end else begin
          if (hphase == HP_WORKING) begin
            hum_val = adc;
            stop    = 1'b1;
            hphase  = HP_END;
          end
          level = 1'b0;
        end
        excite_odd = ~excite_odd;
      end
      OP_POLL: begin
        iv = wm ? work_iv : idle_iv;
        case (seq)
          SQ_IDLE: begin
            if (due(now, temp_last, iv)) begin
              stop      = 1'b1;
              start     = 1'b1;
              channel   = CH_TEMP;
              busy      = 1'b1;
              seq       = SQ_TEMP;
              temp_last = now;
            end else if (due(now, hum_last, iv)) begin
              stop    = 1'b1;
              channel = CH_HUM;
              if (hphase == HP_INIT) tstart = 1'b1;
              hphase   = HP_START;
              seq      = SQ_HUM;
              hum_last = now;
            end else if (due(now, ir_last, pir_iv) && auto_ir) begin
              stop    = 1'b1;
              start   = 1'b1;
              channel = CH_IR;
              busy    = 1'b1;
              seq     = SQ_IR;
              ir_last = now;
            end
          end
          SQ_TEMP: begin
            if (!busy) begin
              stop     = 1'b1;
              temp_val = push_average(adc);
              seq      = SQ_IDLE;
              averages_n++;
            end
          end
          SQ_HUM: begin
            if (hphase == HP_END) begin
              stop   = 1'b1;
              hphase = HP_IDLE;
              seq    = SQ_IDLE;
            end
          end
          default: begin
            if (!busy) begin
              stop   = 1'b1;
              ir_val = adc;
              pulse  = presence_step(now);
              seq    = SQ_IDLE;
            end
          end
        endcase
      end
      default: ;
    endcase
    r.channel        = channel;
    r.adc_start      = start;
    r.adc_stop       = stop;
    r.excite_start   = tstart;
    r.excite_level   = level;
    r.temperature    = temp_val;
    r.humidity       = hum_val;
    r.infrared       = ir_val;
    r.presence_pulse = pulse;
    if (pulse) pulses_n++;
    act = start | stop | tstart | pulse | (op == OP_EXCITE) | (op == OP_CONV_END && was_busy);
  endtask

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      bad++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // oldest expectation against each result, then the register port, then new items
  always @(posedge clk) begin
    seq_out_t want, got;
    logic     act;
    if (rst) begin
      reset_model();
      sequencer_outputs_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = seq_out_t'(m_tdata[36:0]);
        if (sequencer_outputs_q.size() == 0) begin
          bad++;
          $error("result item with no expectation waiting: %h", m_tdata);
        end else begin
          want = sequencer_outputs_q.pop_front();
          seen_n++;
          compare_field("adc_channel", want.channel, got.channel);
          compare_field("adc_start", want.adc_start, got.adc_start);
          compare_field("adc_stop", want.adc_stop, got.adc_stop);
          compare_field("excite_timer_start", want.excite_start, got.excite_start);
          compare_field("excite_level", want.excite_level, got.excite_level);
          compare_field("temperature", want.temperature, got.temperature);
          compare_field("humidity", want.humidity, got.humidity);
          compare_field("infrared", want.infrared, got.infrared);
          compare_field("presence_pulse", want.presence_pulse, got.presence_pulse);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_IDLE_INTERVAL: idle_iv = cfg_data;
          REG_WORK_INTERVAL: work_iv = cfg_data;
          REG_PIR_INTERVAL:  pir_iv = cfg_data;
          REG_PIR_THRESHOLD: threshold = cfg_data[9:0];
          REG_PIR_DWELL:     dwell = cfg_data;
          REG_PIR_ENABLE:    enable = cfg_data[0];
          REG_PIR_AUTO:      auto_ir = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        sequence_step(op_t'(s_tuser), s_tdata[15:0], s_tdata[25:16], s_tdata[26], want, act);
        sequencer_outputs_q.push_back(want);
        if (act) active_n++;
      end
    end
    mismatches      <= bad;
    outstanding     <= sequencer_outputs_q.size();
    active_items    <= active_n;
    results_seen    <= seen_n;
    presence_pulses <= pulses_n;
    averages_done   <= averages_n;
  end

endmodule

// File: tb/sv/sensor_adc_sequencer_tb.sv
// testbench top for the sensor adc sequencer: clock, reset, stimulus and verdict
module sensor_adc_sequencer_tb;
  import sads_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS = 1250;
  localparam int LIMIT = 2_000_000;

  logic                      clk;
  logic                      rst;
  logic [1:0]                s_tuser;
  logic [31:0]               s_tdata;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [39:0]               m_tdata;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  logic [31:0] mismatches, outstanding, active_items, results_seen;
  logic [31:0] presence_pulses, averages_done;

  logic        quiet = 1'b0;
  int          stall_left = 0;
  int          cycles = 0;
  int          sent = 0;
  int          phases = 0;
  int          step_max = 1;
  logic        phase_work = 1'b0;
  logic [15:0] tick = '0;
  logic [9:0]  cur_thr = 10'(PIR_THRESHOLD_RESET);

  sensor_adc_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sensor_adc_sequencer_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tuser         (s_tuser),
    .s_tdata         (s_tdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .m_tdata         (m_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .active_items    (active_items),
    .results_seen    (results_seen),
    .presence_pulses (presence_pulses),
    .averages_done   (averages_done)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("sensor_adc_sequencer regression: fail");
      $finish;
    end
  end

  // receiver stalls: mostly short, now and then long, none in quiet phases
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      m_tready   <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // readings spread over the range and bunched around the presence level
  function automatic logic [9:0] rand_adc();
    case ($urandom_range(0, 5))
      0: return 10'($urandom_range(0, cur_thr));
      1: return cur_thr + 10'($urandom_range(0, 2)) - 10'd1;
      2: return 10'($urandom_range(cur_thr, 1023));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic rand_work();
    return ($urandom_range(0, 9) == 0) ? ~phase_work : phase_work;
  endfunction

  function automatic logic [15:0] rand_interval();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 60));
    endcase
  endfunction

  function automatic logic [9:0] rand_threshold();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [15:0] rand_dwell();
    case ($urandom_range(0, 9))
      0, 1: return 16'd0;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 60));
    endcase
  endfunction

  // one item, after a random gap, held until accepted
  task automatic send(input op_t op, input logic [15:0] now, input logic [9:0] adc,
                      input logic wm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {5'b0, wm, adc, now};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // hold off until every result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] idle_iv, input logic [15:0] work_iv,
                             input logic [15:0] pir_iv, input logic [9:0] thr,
                             input logic [15:0] dwell, input logic en, input logic au);
    write_reg(REG_IDLE_INTERVAL, idle_iv);
    write_reg(REG_WORK_INTERVAL, work_iv);
    write_reg(REG_PIR_INTERVAL, pir_iv);
    write_reg(REG_PIR_THRESHOLD, {6'b0, thr});
    write_reg(REG_PIR_DWELL, dwell);
    write_reg(REG_PIR_ENABLE, {15'b0, en});
    write_reg(REG_PIR_AUTO, {15'b0, au});
    cfg_we  <= 1'b0;
    cur_thr = thr;
  endtask

  // start, complete and close one infrared sample
  task automatic sample_ir(input logic [9:0] adc);
    send(OP_POLL, 16'd1000, 10'd0, 1'b0);
    send(OP_CONV_END, 16'd1000, 10'd0, 1'b0);
    send(OP_POLL, 16'd1000, adc, 1'b0);
  endtask

  function automatic logic [15:0] next_tick();
    return tick + 16'($urandom_range(0, step_max));
  endfunction

  // mostly complete poll, complete, poll, excite, excite, poll rounds; the rest loose items
  task automatic run_phase(input int len);
    int n;
    int k;
    n = 0;
    while (n < len && sent < ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        tick = next_tick();
        send(OP_POLL, tick, rand_adc(), rand_work());
        send(OP_CONV_END, tick, rand_adc(), rand_work());
        tick = next_tick();
        send(OP_POLL, tick, rand_adc(), rand_work());
        send(OP_EXCITE, tick, rand_adc(), rand_work());
        send(OP_EXCITE, tick, rand_adc(), rand_work());
        tick = next_tick();
        send(OP_POLL, tick, rand_adc(), rand_work());
        n += 6;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          tick = ($urandom_range(0, 3) == 0) ? 16'($urandom) : next_tick();
          send(op_t'($urandom_range(0, 3)), tick, rand_adc(), rand_work());
        end
        n += k;
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= OP_POLL;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_IDLE_INTERVAL;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: ignored and out-of-order items, a temperature and a humidity run
    send(OP_UNUSED, 16'd0, 10'd1023, 1'b1);
    send(OP_CONV_END, 16'd0, 10'd0, 1'b0);
    send(OP_EXCITE, 16'd0, 10'd0, 1'b0);
    send(OP_POLL, 16'd10, 10'd0, 1'b0);
    send(OP_POLL, 16'd50, 10'd0, 1'b0);
    send(OP_CONV_END, 16'd55, 10'd0, 1'b0);
    send(OP_POLL, 16'd60, 10'd1023, 1'b0);
    send(OP_POLL, 16'd60, 10'd0, 1'b0);
    send(OP_EXCITE, 16'd61, 10'd5, 1'b0);
    send(OP_EXCITE, 16'd62, 10'd1023, 1'b0);
    send(OP_POLL, 16'd63, 10'd0, 1'b0);
    // tick wrap in work mode, second temperature sample into the mean
    send(OP_POLL, 16'hFFFF, 10'd0, 1'b1);
    send(OP_CONV_END, 16'hFFFF, 10'd0, 1'b1);
    send(OP_POLL, 16'hFFFF, 10'd0, 1'b1);

    // infrared only: detection while disabled, re-enable, presence and pulse
    drain();
    load_config(16'hFFFF, 16'hFFFF, 16'd0, 10'(PIR_THRESHOLD_RESET), 16'd0, 1'b0, 1'b1);
    sample_ir(10'd1023);
    drain();
    load_config(16'hFFFF, 16'hFFFF, 16'd0, 10'(PIR_THRESHOLD_RESET), 16'd0, 1'b1, 1'b1);
    sample_ir(10'd900);
    sample_ir(10'(PIR_THRESHOLD_RESET + 1));
    sample_ir(10'd1023);

    // random phases, each behind a full drain and a new register set
    while (sent < ITEMS) begin
      drain();
      phase_work = 1'($urandom_range(0, 1));
      step_max   = $urandom_range(1, 30);
      load_config(rand_interval(), rand_interval(), rand_interval(), rand_threshold(),
                  rand_dwell(), $urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0);
      quiet <= (phases % 4 == 3);
      phases++;
      run_phase($urandom_range(60, 250));
    end

    drain();
    repeat (40) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d with converter or excitation activity",
             sent, results_seen, active_items);
    $display("%0d register phases, %0d temperature means, %0d presence pulses",
             phases, averages_done, presence_pulses);
    if (mismatches == 0) begin
      $display("sensor_adc_sequencer regression: pass");
    end else begin
      $display("sensor_adc_sequencer regression: fail");
    end
    $finish;
  end

endmodule
